// ===== hw/rtl/power_law_audio_compressor_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the power law audio compressor
// Concurrent checks that build away to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef POWER_LAW_AUDIO_COMPRESSOR_UNIT_MACROS_SVH
`define POWER_LAW_AUDIO_COMPRESSOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PLAC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PLAC_ASSERT_IMPLY(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`else
`define PLAC_ASSERT(lbl, prop, msg)
`define PLAC_ASSERT_IMPLY(lbl, pre, post, msg)
`endif
`endif

// ===== hw/rtl/plac_pkg.sv =====
// ----------------------------------------------------------------------------
// plac_pkg
// Types, register indexes and constant tables of the compressor.
// ----------------------------------------------------------------------------
package plac_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_DRY_MIX       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_EXPONENT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_COEFF   = 2'd2;

    localparam logic [15:0]        DRY_MIX_RST       = 16'd0;
    localparam logic signed [15:0] GAIN_EXPONENT_RST = -16'sd819;
    localparam logic [23:0]        DECAY_COEFF_RST   = 24'd1522;

    localparam logic [15:0] DRY_FULL  = 16'd32768;
    localparam logic [31:0] MANT_ONE  = 32'h4000_0000;
    localparam logic [31:0] GAIN_UNIT = 32'h0001_0000;
    localparam logic [31:0] GAIN_SAT  = 32'hFFFF_FFFF;
    localparam int          LOG_STEPS = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NORM,
        ST_LOG,
        ST_YMUL,
        ST_YCAP,
        ST_EXP,
        ST_GAIN,
        ST_WET,
        ST_DMUL,
        ST_HMUL,
        ST_LMUL,
        ST_MIX,
        ST_OUT
    } plac_state_t;

    typedef logic [LOG_STEPS-1:0][31:0] root_tab_t;

    function automatic logic [63:0] isqrt64(logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = 64'd0;
        b = 64'h4000_0000_0000_0000;
        for (int n = 0; n < 32; n++)
        begin
            if (b > v)
                b = b >> 2;
        end
        for (int n = 0; n < 32; n++)
        begin
            if (b != 64'd0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // root[i] = 2^(2^-(i+1)) in Q1.30
    function automatic root_tab_t build_roots();
        root_tab_t t;
        t[0] = 32'(isqrt64(64'h1 << 61));
        for (int i = 1; i < LOG_STEPS; i++)
            t[i] = 32'(isqrt64(64'({t[i-1], 30'b0})));
        return t;
    endfunction

    localparam root_tab_t ROOT_TAB = build_roots();

endpackage

// ===== hw/rtl/power_law_audio_compressor_unit.sv =====
// ----------------------------------------------------------------------------
// power_law_audio_compressor_unit
// Peak envelope compressor: gain = envelope^exponent, dry/wet mix, clip flag.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall   | in_sample
//  out     | output    | out_valid / out_stall | out_sample, clipped
//  cfg     | input     | cfg_we                | cfg_index, cfg_data
//
//  A word goes from accept to output through the leading-zero shift, the
//  squaring log2 loop and the root product exp2 loop, then 9 multiply, gain
//  and mix steps, all on one shared 33x33 signed multiplier. A zero envelope
//  skips the shift, log2 and exp2 and sets the gain at accept.
//  in_stall is high while a word is in work; a held output stops the last step.
//  Reset clears the envelope and loads the register defaults.
// ----------------------------------------------------------------------------
`include "power_law_audio_compressor_unit_macros.svh"

module power_law_audio_compressor_unit #(
    parameter int SAMPLE_BITS   = 16,
    parameter int ENV_FRAC_BITS = 24
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [SAMPLE_BITS-1:0]    in_sample,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [SAMPLE_BITS-1:0]    out_sample,
    output logic                             clipped,
    input  logic                             cfg_we,
    input  logic [plac_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [plac_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import plac_pkg::*;

    localparam int SB  = SAMPLE_BITS;
    localparam int EF  = ENV_FRAC_BITS;
    localparam int EW  = EF + 1;
    localparam int MW  = (EW + 1 > 33) ? ((EW + 1 > SB) ? EW + 1 : SB)
                                       : ((SB > 33) ? SB : 33);
    localparam int PW  = 2 * MW;
    localparam int AW  = SB + 32;
    localparam int WW  = SB + 17;
    localparam int CW  = $clog2(EF + 1);
    localparam int ITW = 5;

    localparam logic [EW-1:0]        ENV_FULL = {1'b1, {EF{1'b0}}};
    localparam logic signed [WW-1:0] SMAX = {{18{1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [WW-1:0] SMIN = {{18{1'b1}}, {(SB-1){1'b0}}};

    plac_state_t state_reg, state_next;

    logic [15:0]               dry_reg, dry_next;
    logic signed [15:0]        gexp_reg, gexp_next;
    logic [23:0]               decay_reg, decay_next;
    logic [EW-1:0]             env_reg, env_next;
    logic signed [SB-1:0]      s_reg, s_next;
    logic [EW-1:0]             nv_reg, nv_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic [ITW-1:0]            i_reg, i_next;
    logic [30:0]               m_reg, m_next;
    logic [15:0]               frac_reg, frac_next;
    logic signed [11:0]        k_reg, k_next;
    logic [15:0]               f_reg, f_next;
    logic [31:0]               mant_reg, mant_next;
    logic [31:0]               gain_reg, gain_next;
    logic                      sat_reg, sat_next;
    logic signed [WW-1:0]      wet_reg, wet_next;
    logic signed [AW-1:0]      acc_reg, acc_next;
    logic signed [PW-1:0]      p_reg;
    logic signed [SB-1:0]      out_sample_reg, out_sample_next;
    logic                      clipped_reg, clipped_next;
    logic                      out_valid_reg, out_valid_next;

    logic                      mul_en;
    logic signed [MW-1:0]      mul_a, mul_b;
    logic signed [PW-1:0]      prod;

    logic                      in_acc;
    logic                      out_free;
    logic [SB-1:0]             mag;
    logic [SB+EF-1:0]          mag_cat;
    logic [EW-1:0]             mag_sc;
    logic [EW-1:0]             env_new;
    logic [EW+30:0]            nv_cat;
    logic [31:0]               sq;
    logic [30:0]               sq_n;
    logic [30:0]               cur_m;
    logic [31:0]               cur_mant;
    logic [CW:0]               neg_cnt;
    logic signed [12:0]        rs;
    logic [15:0]               dry_sat;
    logic [15:0]               wet_share;
    logic signed [WW-1:0]      mix;

    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign clipped    = clipped_reg;

    assign mag     = in_sample[SB-1] ? (~in_sample + 1'b1) : in_sample;
    assign mag_cat = {mag, {EF{1'b0}}};
    assign mag_sc  = mag_cat[SB-1 +: EW];
    assign env_new = (mag_sc > env_reg) ? mag_sc : env_reg;

    assign nv_cat  = {nv_reg, 31'b0};
    assign sq      = p_reg[61:30];
    assign sq_n    = sq[31] ? sq[31:1] : sq[30:0];
    assign cur_m   = (i_reg == '0) ? m_reg : sq_n;
    assign cur_mant = (i_reg == '0) ? MANT_ONE : (f_reg[15] ? p_reg[61:30] : mant_reg);
    assign neg_cnt = (CW+1)'(0) - (CW+1)'(cnt_reg);
    assign rs      = 13'sd14 - 13'(k_reg);
    assign dry_sat = (dry_reg > DRY_FULL) ? DRY_FULL : dry_reg;
    assign wet_share = DRY_FULL - dry_sat;
    assign mix     = $signed(acc_reg[AW-1:15]);

    assign prod = PW'(mul_a) * PW'(mul_b);

    always_comb
    begin
        state_next = state_reg;
        dry_next   = dry_reg;
        gexp_next  = gexp_reg;
        decay_next = decay_reg;
        env_next   = env_reg;
        s_next     = s_reg;
        nv_next    = nv_reg;
        cnt_next   = cnt_reg;
        i_next     = i_reg;
        m_next     = m_reg;
        frac_next  = frac_reg;
        k_next     = k_reg;
        f_next     = f_reg;
        mant_next  = mant_reg;
        gain_next  = gain_reg;
        sat_next   = sat_reg;
        wet_next   = wet_reg;
        acc_next   = acc_reg;
        out_sample_next = out_sample_reg;
        clipped_next    = clipped_reg;
        out_valid_next  = out_valid_reg && out_stall;
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DRY_MIX:       dry_next   = cfg_data[15:0];
                CFG_GAIN_EXPONENT: gexp_next  = $signed(cfg_data[15:0]);
                CFG_DECAY_COEFF:   decay_next = cfg_data;
                default:           ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    s_next   = in_sample;
                    env_next = env_new;
                    nv_next  = env_new;
                    cnt_next = '0;
                    sat_next = 1'b0;
                    if (env_new == '0)
                    begin
                        if (gexp_reg < 0)
                        begin
                            gain_next = GAIN_SAT;
                            sat_next  = 1'b1;
                        end
                        else if (gexp_reg == 0)
                            gain_next = GAIN_UNIT;
                        else
                            gain_next = '0;
                        state_next = ST_WET;
                    end
                    else
                        state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (nv_reg[EW-1])
                begin
                    m_next     = nv_cat[EW+30 -: 31];
                    i_next     = '0;
                    state_next = ST_LOG;
                end
                else if (nv_reg[EW-1 -: 4] == 4'b0)
                begin
                    nv_next  = nv_reg << 4;
                    cnt_next = cnt_reg + CW'(4);
                end
                else
                begin
                    nv_next  = nv_reg << 1;
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_LOG:
            begin
                if (i_reg == '0)
                    frac_next = '0;
                else
                    frac_next = {frac_reg[14:0], sq[31]};
                m_next = cur_m;
                if (i_reg == ITW'(LOG_STEPS))
                    state_next = ST_YMUL;
                else
                begin
                    mul_en = 1'b1;
                    mul_a  = MW'({1'b0, cur_m});
                    mul_b  = MW'({1'b0, cur_m});
                    i_next = i_reg + 1'b1;
                end
            end
            ST_YMUL:
            begin
                mul_en = 1'b1;
                mul_a  = MW'($signed({neg_cnt, frac_reg}));
                mul_b  = MW'(gexp_reg);
                state_next = ST_YCAP;
            end
            ST_YCAP:
            begin
                k_next = $signed(p_reg[39:28]);
                f_next = p_reg[27:12];
                i_next = '0;
                state_next = ST_EXP;
            end
            ST_EXP:
            begin
                mant_next = cur_mant;
                if (i_reg != '0)
                    f_next = f_reg << 1;
                if (i_reg == ITW'(LOG_STEPS))
                    state_next = ST_GAIN;
                else
                begin
                    mul_en = 1'b1;
                    mul_a  = MW'({1'b0, cur_mant});
                    mul_b  = MW'({1'b0, ROOT_TAB[i_reg[3:0]]});
                    i_next = i_reg + 1'b1;
                end
            end
            ST_GAIN:
            begin
                priority if (k_reg >= 12'sd16)
                begin
                    gain_next = GAIN_SAT;
                    sat_next  = 1'b1;
                end
                else if (k_reg == 12'sd15)
                    gain_next = mant_reg << 1;
                else if (k_reg == 12'sd14)
                    gain_next = mant_reg;
                else if (rs >= 13'sd32)
                    gain_next = '0;
                else
                    gain_next = mant_reg >> rs[4:0];
                state_next = ST_WET;
            end
            ST_WET:
            begin
                mul_en = 1'b1;
                mul_a  = MW'(s_reg);
                mul_b  = MW'({1'b0, gain_reg});
                state_next = ST_DMUL;
            end
            ST_DMUL:
            begin
                wet_next = $signed(p_reg[SB+32:16]);
                mul_en = 1'b1;
                mul_a  = MW'(s_reg);
                mul_b  = MW'({1'b0, dry_sat});
                state_next = ST_HMUL;
            end
            ST_HMUL:
            begin
                acc_next = AW'(p_reg);
                mul_en = 1'b1;
                mul_a  = MW'({1'b0, wet_share});
                mul_b  = MW'($signed(wet_reg[WW-1:17]));
                state_next = ST_LMUL;
            end
            ST_LMUL:
            begin
                acc_next = acc_reg + (AW'(p_reg) <<< 17);
                mul_en = 1'b1;
                mul_a  = MW'({1'b0, wet_share});
                mul_b  = MW'({1'b0, wet_reg[16:0]});
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                acc_next = acc_reg + AW'(p_reg);
                mul_en = 1'b1;
                mul_a  = MW'({1'b0, env_reg});
                mul_b  = MW'({1'b0, decay_reg});
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    priority if (mix > SMAX)
                    begin
                        out_sample_next = SMAX[SB-1:0];
                        clipped_next    = 1'b1;
                    end
                    else if (mix < SMIN)
                    begin
                        out_sample_next = SMIN[SB-1:0];
                        clipped_next    = 1'b1;
                    end
                    else
                    begin
                        out_sample_next = mix[SB-1:0];
                        clipped_next    = sat_reg;
                    end
                    out_valid_next = 1'b1;
                    env_next   = env_reg - p_reg[24 +: EW];
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dry_reg       <= DRY_MIX_RST;
            gexp_reg      <= GAIN_EXPONENT_RST;
            decay_reg     <= DECAY_COEFF_RST;
            env_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dry_reg       <= dry_next;
            gexp_reg      <= gexp_next;
            decay_reg     <= decay_next;
            env_reg       <= env_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg    <= s_next;
        nv_reg   <= nv_next;
        cnt_reg  <= cnt_next;
        i_reg    <= i_next;
        m_reg    <= m_next;
        frac_reg <= frac_next;
        k_reg    <= k_next;
        f_reg    <= f_next;
        mant_reg <= mant_next;
        gain_reg <= gain_next;
        sat_reg  <= sat_next;
        wet_reg  <= wet_next;
        acc_reg  <= acc_next;
        out_sample_reg <= out_sample_next;
        clipped_reg    <= clipped_next;
        if (mul_en)
            p_reg <= prod;
    end

    `PLAC_ASSERT_IMPLY(a_env_full, 1'b1, env_reg <= ENV_FULL, "envelope above full scale")
    `PLAC_ASSERT_IMPLY(a_norm_nonzero, state_reg == ST_NORM, nv_reg != '0, "normalize on zero")
    `PLAC_ASSERT_IMPLY(a_norm_cnt, state_reg == ST_NORM, cnt_reg <= CW'(EF), "shift count overrun")
    `PLAC_ASSERT(a_accept_busy, in_acc |=> state_reg != ST_IDLE, "accepted word not in work")
    `PLAC_ASSERT(a_out_src, $rose(out_valid) |-> $past(state_reg) == ST_OUT, "stray output word")

endmodule

// ===== tb/power_law_audio_compressor_unit_tb.sv =====
// ----------------------------------------------------------------------------
// power_law_audio_compressor_unit_tb
// Drives signed samples through the compressor across a series of register
// settings. A scoreboard tracks the peak envelope, predicts every output word
// and clip flag, and compares them in order with what the block delivers.
// ----------------------------------------------------------------------------
module power_law_audio_compressor_unit_tb;
    import plac_pkg::*;

    typedef struct packed
    {
        logic [15:0] smp;
        logic        clip;
    } comp_word_t;

    class comp_scoreboard;
        longint unsigned env;
        longint          dry;
        logic signed [15:0] gexp;
        longint unsigned decay;
        longint unsigned roots[16];
        comp_word_t      pending_q[$];
        int              errors;
        int              checked;

        function longint unsigned sqrt_floor(longint unsigned v);
            longint unsigned r;
            longint unsigned t;
            r = 0;
            for (int b = 31; b >= 0; b--)
            begin
                t = r | (64'd1 << b);
                if (t * t <= v)
                    r = t;
            end
            return r;
        endfunction

        function new();
            env = 0;
            dry = 0;
            gexp = -16'sd819;
            decay = 1522;
            errors = 0;
            checked = 0;
            roots[0] = sqrt_floor(64'd1 << 61);
            for (int i = 1; i < 16; i++)
                roots[i] = sqrt_floor(roots[i-1] << 30);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_DRY_MIX)
                dry = val[15:0];
            else if (idx == CFG_GAIN_EXPONENT)
                gexp = val[15:0];
            else if (idx == CFG_DECAY_COEFF)
                decay = val[23:0];
        endfunction

        function void note_input(logic signed [15:0] smp);
            longint          s, exv, lg, y, k, wet, mix, d;
            longint unsigned mag, gain, mant, m, f;
            int              p;
            int unsigned     frac;
            bit              sat;
            comp_word_t      w;
            sat = 0;
            s = smp;
            mag = (s < 0) ? -s : s;
            mag = mag << 9;
            if (mag > env)
                env = mag;
            exv = gexp;
            if (env == 0)
            begin
                if (exv < 0)
                begin
                    sat = 1;
                    gain = 64'hFFFF_FFFF;
                end
                else
                    gain = (exv == 0) ? 64'd65536 : 64'd0;
            end
            else
            begin
                p = 63;
                while (p > 0 && !env[p])
                    p--;
                m = (p <= 30) ? (env << (30 - p)) : (env >> (p - 30));
                frac = 0;
                for (int i = 0; i < 16; i++)
                begin
                    m = (m * m) >> 30;
                    frac = frac << 1;
                    if (m >= (64'd1 << 31))
                    begin
                        m = m >> 1;
                        frac = frac | 1;
                    end
                end
                lg = longint'(p - 24) * 65536 + longint'(frac);
                y = (lg * exv) >>> 12;
                k = y >>> 16;
                f = y & 64'hFFFF;
                mant = 64'd1 << 30;
                for (int i = 0; i < 16; i++)
                    if (f[15-i])
                        mant = (mant * roots[i]) >> 30;
                if (k >= 16)
                begin
                    sat = 1;
                    gain = 64'hFFFF_FFFF;
                end
                else if (k >= 14)
                    gain = mant << (k - 14);
                else if (14 - k >= 40)
                    gain = 0;
                else
                    gain = mant >> (14 - k);
            end
            wet = (s * longint'(gain)) >>> 16;
            d = (dry > 32768) ? 32768 : dry;
            mix = (s * d + (32768 - d) * wet) >>> 15;
            if (mix > 32767)
            begin
                mix = 32767;
                sat = 1;
            end
            else if (mix < -32768)
            begin
                mix = -32768;
                sat = 1;
            end
            w.smp = mix[15:0];
            w.clip = sat;
            pending_q.push_back(w);
            env = env - ((env * decay) >> 24);
        endfunction

        function void check(logic [15:0] smp, logic clip);
            comp_word_t w;
            checked++;
            if (pending_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word out_sample=%0d clipped=%0b",
                         $time, $signed(smp), clip);
                return;
            end
            w = pending_q.pop_front();
            if (w.smp !== smp)
            begin
                errors++;
                $display("%0t: out_sample expected %0d actual %0d",
                         $time, $signed(w.smp), $signed(smp));
            end
            if (w.clip !== clip)
            begin
                errors++;
                $display("%0t: clipped expected %0b actual %0b", $time, w.clip, clip);
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic signed [15:0]    in_sample;
    logic                  out_valid;
    logic                  out_stall;
    logic signed [15:0]    out_sample;
    logic                  clipped;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    comp_scoreboard sb;
    bit             quiet;
    int             sent;
    int             phases;

    power_law_audio_compressor_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_sample  (in_sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_sample (out_sample),
        .clipped    (clipped),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_input(in_sample);
        if (rst_n && out_valid && !out_stall)
            sb.check(out_sample, clipped);
    end

    always @(posedge clk)
        out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 31);

    task automatic send_sample(logic signed [15:0] s);
        if (!quiet && $urandom_range(99) < 31)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_sample <= s;
        do
            @(posedge clk);
        while (in_stall);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_all(logic [23:0] d, logic [23:0] e, logic [23:0] c);
        drain();
        write_reg(CFG_DRY_MIX, d);
        write_reg(CFG_GAIN_EXPONENT, e);
        write_reg(CFG_DECAY_COEFF, c);
        phases++;
    endtask

    function automatic logic signed [15:0] pick_sample();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return 16'($urandom());
        else if (r < 60)
            return $signed(16'($urandom_range(0, 512))) - 16'sd256;
        else if (r < 80)
            return $urandom_range(1) ? 16'sd32767 - 16'($urandom_range(2000))
                                     : 16'sh8000 + 16'($urandom_range(2000));
        else
            return $signed(16'($urandom_range(0, 8))) - 16'sd4;
    endfunction

    initial
    begin
        sb = new();
        rst_n = 0;
        in_valid = 0;
        in_sample = 0;
        cfg_we = 0;
        cfg_index = 0;
        cfg_data = 0;
        quiet = 0;
        sent = 0;
        phases = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // zero envelope with the three exponent signs
        send_sample(16'sd0);
        send_sample(16'sd0);
        drain();
        write_reg(CFG_GAIN_EXPONENT, 24'd0);
        send_sample(16'sd0);
        drain();
        write_reg(CFG_GAIN_EXPONENT, 24'd4096);
        send_sample(16'sd0);
        set_all(24'd0, 24'hFFFCCD, 24'd1522);
        send_sample(16'sd32767);
        send_sample(16'sh8000);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        send_sample(16'sd0);
        // dry above full, upper data bits dropped, unknown index ignored
        set_all(24'hFFFFFF, 24'hFF8000, 24'hFFFFFF);
        write_reg(2'd3, 24'h123456);
        send_sample(16'sd12345);
        send_sample(-16'sd20000);
        send_sample(16'sd3);
        set_all(24'd32768, 24'd32767, 24'd0);
        send_sample(16'sd32767);
        send_sample(-16'sd5);
        set_all(24'd16384, 24'hFF8000, 24'd1);
        send_sample(16'sd100);
        send_sample(16'sh8000);
        send_sample(16'sd1);
        set_all(24'd0, 24'd32767, 24'hFFFFFF);
        send_sample(16'sd1);
        send_sample(16'sh8000);
        send_sample(16'sd2);

        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0: set_all(24'd0, 24'hFFFCCD, 24'd1522);
                1: set_all(24'd32768, 24'h007FFF, 24'hFFFFFF);
                2: set_all(24'd0, 24'hFF8000, 24'd0);
                3: set_all(24'hFFFFFF, 24'd0, 24'd1);
                default: set_all(24'($urandom_range(0, 40000)),
                                 24'($urandom()),
                                 $urandom_range(1) ? 24'($urandom()) :
                                 24'($urandom_range(0, 5000)));
            endcase
            for (int n = 0; n < 150; n++)
            begin
                quiet = (ph == 5) && (n < 100);
                send_sample(pick_sample());
            end
            quiet = 0;
        end

        drain();
        $display("Sent %0d samples over %0d register settings, %0d words checked.",
                 sent, phases + 1, sb.checked);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Timeout with %0d words outstanding.", sb.pending_q.size());
        $display("*** FAILED ***");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/plac_pkg.sv
hw/rtl/power_law_audio_compressor_unit.sv
tb/power_law_audio_compressor_unit_tb.sv
